>>> hdl/wpa_pkg.sv
// Shared constants and control types for the window peak autoscale block.
package wpa_pkg;

    localparam int WINDOW_DEPTH = 64;
    localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
    localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);

    localparam int SAMPLE_W = 24;
    localparam int PEAK_W   = 23;
    localparam int SCALE_W  = 20;
    localparam int HEIGHT_W = 12;
    localparam int CNT_W    = 5;

    // Dividend is height*1152, divisor is peak*5.
    localparam int NUM_W     = 23;
    localparam int DEN_W     = 26;
    localparam int DIV_CNT_W = $clog2(NUM_W);

    localparam logic [CNT_W-1:0]    RESCAN_AT     = CNT_W'(21);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET  = HEIGHT_W'(128);
    localparam logic [PEAK_W-1:0]   PEAK_RESET    = PEAK_W'(1);
    localparam logic [SCALE_W-1:0]  SCALE_MAX     = {SCALE_W{1'b1}};
    localparam logic [SCALE_W-1:0]  SCALE_UNITY   = SCALE_W'(256);

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic clear;
        logic push;
        logic scan_step;
        logic set_peak;
        logic div_start;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_clear;
        logic is_neg;
        logic rescan_due;
        logic scan_last;
        logic div_done;
        logic out_free;
    } t_stat;

endpackage

>>> hdl/wpa_if.sv
// Request channel interfaces for the input samples and the scale results.
interface wpa_in_if;
    import wpa_pkg::*;
    logic                       valid;
    logic                       ready;
    logic                       cmd;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output cmd, output sample, input ready);
    modport sink   (input valid, input cmd, input sample, output ready);
endinterface

interface wpa_out_if;
    import wpa_pkg::*;
    logic               valid;
    logic               ready;
    logic [PEAK_W-1:0]  peak;
    logic [SCALE_W-1:0] scale_q8;
    logic               rescanned;

    modport source (output valid, output peak, output scale_q8, output rescanned, input ready);
    modport sink   (input valid, input peak, input scale_q8, input rescanned, output ready);
endinterface

>>> hdl/wpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> hdl/wpa_divider.sv
// Restoring serial divider producing one quotient bit per cycle.
module wpa_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [wpa_pkg::NUM_W-1:0]   i_num,
    input  logic [wpa_pkg::DEN_W-1:0]   i_den,
    output logic                        o_done,
    output logic [wpa_pkg::NUM_W-1:0]   o_quo
);
    import wpa_pkg::*;

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [DEN_W-1:0]     r_den, n_den;
    logic [DEN_W-1:0]     r_rem, n_rem;
    logic [NUM_W-1:0]     r_quo, n_quo;
    logic [DEN_W:0]       w_trial;
    logic                 w_fits;

    assign w_trial = {r_rem, r_quo[NUM_W-1]};
    assign w_fits  = w_trial >= {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_den  = r_den;
        n_rem  = r_rem;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_den  = i_den;
            n_rem  = '0;
            n_quo  = i_num;
        end else if (r_busy) begin
            n_rem = w_fits ? DEN_W'(w_trial - {1'b0, r_den}) : DEN_W'(w_trial);
            n_quo = {r_quo[NUM_W-2:0], w_fits};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(NUM_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_den <= n_den;
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

>>> hdl/wpa_datapath.sv
// Window store, peak tracking, scan, scale division and result register.
module wpa_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  wpa_pkg::t_cmd                  i_cmd,
    output wpa_pkg::t_stat                 o_stat,
    input  logic                           i_cfg_we,
    input  logic [wpa_pkg::HEIGHT_W-1:0]   i_cfg_wdata,
    input  logic                           i_in_cmd,
    input  logic [wpa_pkg::SAMPLE_W-1:0]   i_in_sample,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [wpa_pkg::PEAK_W-1:0]     o_out_peak,
    output logic [wpa_pkg::SCALE_W-1:0]    o_out_scale,
    output logic                           o_out_rescanned
);
    import wpa_pkg::*;

    logic [HEIGHT_W-1:0] r_height;
    logic                r_cmd_q;
    logic [SAMPLE_W-1:0] r_sample_q;
    logic [PEAK_W-1:0]   r_peak;
    logic [CNT_W-1:0]    r_count;
    logic [ADDR_W-1:0]   r_wp;
    logic [FILL_W-1:0]   r_fill;
    logic [ADDR_W-1:0]   r_scan_addr;
    logic                r_rd_vld;
    logic                r_rd_ok;
    logic [PEAK_W-1:0]   r_max;
    logic                r_rescan;
    logic                r_is_clear;
    logic                r_out_valid;
    logic [PEAK_W-1:0]   r_out_peak;
    logic [SCALE_W-1:0]  r_out_scale;
    logic                r_out_rescan;

    logic [PEAK_W-1:0] w_value;
    logic [PEAK_W-1:0] w_rdata;
    logic [NUM_W-1:0]  w_num;
    logic [DEN_W-1:0]  w_den;
    logic              w_div_done;
    logic [NUM_W-1:0]  w_quo;
    logic [SCALE_W-1:0] w_scale;
    logic              w_out_free;

    assign w_value    = r_sample_q[PEAK_W-1:0];
    assign w_out_free = !r_out_valid || i_out_ready;

    wpa_ram #(
        .WIDTH (PEAK_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (r_wp),
        .i_wdata (w_value),
        .i_re    (i_cmd.scan_step),
        .i_raddr (r_scan_addr),
        .o_rdata (w_rdata)
    );

    // height*1152 = height*1024 + height*128; peak*5 = peak*4 + peak.
    assign w_num = NUM_W'({r_height, 10'b0}) + NUM_W'({r_height, 7'b0});
    assign w_den = DEN_W'({r_peak, 2'b0}) + DEN_W'(r_peak);

    wpa_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    always_comb begin
        if (r_peak == '0) begin
            w_scale = SCALE_MAX;
        end else if (w_quo > NUM_W'(SCALE_MAX)) begin
            w_scale = SCALE_MAX;
        end else begin
            w_scale = w_quo[SCALE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height    <= HEIGHT_RESET;
            r_peak      <= PEAK_RESET;
            r_count     <= '0;
            r_wp        <= '0;
            r_fill      <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_height <= i_cfg_wdata;
            end
            if (i_cmd.clear) begin
                r_peak  <= PEAK_RESET;
                r_count <= '0;
                r_wp    <= '0;
                r_fill  <= '0;
            end
            if (i_cmd.push) begin
                r_wp <= (r_wp == ADDR_W'(WINDOW_DEPTH - 1)) ? '0 : r_wp + 1'b1;
                if (r_fill != FILL_W'(WINDOW_DEPTH)) begin
                    r_fill <= r_fill + 1'b1;
                end
                if (r_count >= RESCAN_AT) begin
                    r_count <= '0;
                end else begin
                    r_count <= r_count + 1'b1;
                    if (w_value > r_peak) begin
                        r_peak <= w_value;
                    end
                end
            end
            if (i_cmd.set_peak) begin
                r_peak <= r_max;
            end
            r_rd_vld <= i_cmd.scan_step;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd_q    <= i_in_cmd;
            r_sample_q <= i_in_sample;
        end
        if (i_cmd.clear) begin
            r_is_clear <= 1'b1;
        end
        if (i_cmd.push) begin
            r_is_clear  <= 1'b0;
            r_rescan    <= r_count >= RESCAN_AT;
            r_max       <= '0;
            r_scan_addr <= '0;
        end
        if (i_cmd.scan_step) begin
            r_scan_addr <= r_scan_addr + 1'b1;
            // Entries at or above the fill count were cleared and are skipped.
            r_rd_ok     <= FILL_W'(r_scan_addr) < r_fill;
        end
        if (r_rd_vld && r_rd_ok && (w_rdata > r_max)) begin
            r_max <= w_rdata;
        end
        if (i_cmd.load_out) begin
            if (r_is_clear) begin
                r_out_peak   <= PEAK_RESET;
                r_out_scale  <= SCALE_UNITY;
                r_out_rescan <= 1'b0;
            end else begin
                r_out_peak   <= r_peak;
                r_out_scale  <= w_scale;
                r_out_rescan <= r_rescan;
            end
        end
    end

    assign o_stat.is_clear   = r_cmd_q == CMD_CLEAR;
    assign o_stat.is_neg     = r_sample_q[SAMPLE_W-1];
    assign o_stat.rescan_due = r_count >= RESCAN_AT;
    assign o_stat.scan_last  = r_scan_addr == ADDR_W'(WINDOW_DEPTH - 1);
    assign o_stat.div_done   = w_div_done;
    assign o_stat.out_free   = w_out_free;

    assign o_out_valid     = r_out_valid;
    assign o_out_peak      = r_out_peak;
    assign o_out_scale     = r_out_scale;
    assign o_out_rescanned = r_out_rescan;
endmodule

>>> hdl/wpa_ctrl.sv
// Sequencing state machine for the window peak autoscale block.
module wpa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  wpa_pkg::t_stat i_stat,
    output wpa_pkg::t_cmd  o_cmd
);
    import wpa_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECODE = 8'b0000_0010,
        S_SCAN   = 8'b0000_0100,
        S_DRAIN  = 8'b0000_1000,
        S_SETPK  = 8'b0001_0000,
        S_DSTART = 8'b0010_0000,
        S_DIV    = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.is_clear) begin
                    o_cmd.clear = 1'b1;
                    n_state     = S_DONE;
                end else if (i_stat.is_neg) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.push = 1'b1;
                    n_state    = i_stat.rescan_due ? S_SCAN : S_DSTART;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_SETPK;
            end
            S_SETPK: begin
                o_cmd.set_peak = 1'b1;
                n_state        = S_DSTART;
            end
            S_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

>>> hdl/window_peak_autoscale.sv
// Top level of the sliding window peak tracker with autoscale factor output.
//
// This block keeps the last 64 non-negative samples in a window RAM and
// tracks an autoscale peak. Each request carries a command and a 24-bit
// signed sample. A sample request with a negative value is dropped and gives
// no result. Any other sample is written as the newest window entry and
// gives one result with the peak, the scale 0.9*height/peak in unsigned Q.8
// (saturated, all ones for a zero peak) and a rescan flag. A clear request
// empties the window, sets the peak to one and gives peak 1 with scale 1.0.
// The time from a normal sample to its result is set mostly by the serial
// divider, which produces one quotient bit per cycle. Every 22nd sample also
// rescans the window for its true maximum, reading one entry per cycle
// through the single RAM read port before the division. The block takes one
// request at a time; a finished result waits in the output register while
// the next request is accepted and processed. Cleared window entries are
// tracked by a fill count, so neither reset nor clear needs a pass over the
// RAM. The display height register is written through i_cfg_we and
// i_cfg_wdata and should only change while no request is in progress.
module window_peak_autoscale (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    wpa_in_if.sink                       i_in,
    wpa_out_if.source                    o_out,
    input  logic                         i_cfg_we,
    input  logic [wpa_pkg::HEIGHT_W-1:0] i_cfg_wdata
);
    import wpa_pkg::*;

    // Command and status bundles between the sequencer and the datapath.
    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;

    // The sequencer owns request acceptance and the order of datapath steps.
    wpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the window, the peak, the divider and the result.
    wpa_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_cmd        (i_in.cmd),
        .i_in_sample     (i_in.sample),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_out_peak      (o_out.peak),
        .o_out_scale     (o_out.scale_q8),
        .o_out_rescanned (o_out.rescanned)
    );

    assign i_in.ready = w_in_ready;
endmodule

>>> tb/sv/peak_scale_checker.sv
// Checker that predicts and compares the peak and autoscale results of the block.
`timescale 1ns / 100ps

module peak_scale_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    wpa_in_if                            in_mon,
    wpa_out_if                           out_mon,
    input  logic                         i_cfg_we,
    input  logic [wpa_pkg::HEIGHT_W-1:0] i_cfg_wdata,
    output int unsigned                  o_fail_count,
    output int unsigned                  o_pending,
    output int unsigned                  o_checked,
    output int unsigned                  o_rescans
);
    import wpa_pkg::*;

    // The scale is 0.9*height/peak in Q.8, which is height*1152 / (peak*5).
    localparam longint unsigned SCALE_NUM = 1152;
    localparam longint unsigned SCALE_DEN = 5;
    localparam int              REPORT_CAP = 40;

    typedef struct packed {
        logic [PEAK_W-1:0]  peak;
        logic [SCALE_W-1:0] scale_q8;
        logic               rescanned;
    } t_peak_scale;

    // Private copy of the block state.
    logic [PEAK_W-1:0]   window_hist [WINDOW_DEPTH];
    logic [PEAK_W-1:0]   peak_now;
    logic [CNT_W-1:0]    since_rescan;
    logic [HEIGHT_W-1:0] height_now;

    t_peak_scale expected_results[$];
    int unsigned fail_total;
    int unsigned checked_total;
    int unsigned rescan_total;

    function automatic logic [SCALE_W-1:0] autoscale(input logic [HEIGHT_W-1:0] height,
                                                     input logic [PEAK_W-1:0] peak);
        longint unsigned quotient;
        if (peak == '0) begin
            return SCALE_MAX;
        end
        quotient = (longint'(height) * SCALE_NUM) / (longint'(peak) * SCALE_DEN);
        if (quotient > longint'(SCALE_MAX)) begin
            quotient = longint'(SCALE_MAX);
        end
        return quotient[SCALE_W-1:0];
    endfunction

    function automatic void clear_window();
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
            window_hist[i] = '0;
        end
        peak_now     = PEAK_RESET;
        since_rescan = '0;
    endfunction

    // Advances the private state by one request; returns 1 when a result is due.
    function automatic bit predict_peak_scale(input logic cmd,
                                              input logic signed [SAMPLE_W-1:0] sample,
                                              output t_peak_scale res);
        logic [PEAK_W-1:0] newest;
        logic [PEAK_W-1:0] window_max;
        logic              did_rescan;
        res = '0;
        did_rescan = 1'b0;
        if (cmd == CMD_CLEAR) begin
            clear_window();
            res.peak      = PEAK_RESET;
            res.scale_q8  = SCALE_UNITY;
            res.rescanned = 1'b0;
            return 1'b1;
        end
        if (sample < 0) begin
            return 1'b0;
        end
        newest = sample[PEAK_W-1:0];
        for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
            window_hist[i] = window_hist[i+1];
        end
        window_hist[WINDOW_DEPTH-1] = newest;
        if (since_rescan >= RESCAN_AT) begin
            since_rescan = '0;
            did_rescan   = 1'b1;
            window_max   = window_hist[0];
            for (int i = 1; i < WINDOW_DEPTH; i++) begin
                if (window_hist[i] > window_max) begin
                    window_max = window_hist[i];
                end
            end
            peak_now = window_max;
        end else begin
            since_rescan = since_rescan + 1'b1;
            if (newest > peak_now) begin
                peak_now = newest;
            end
        end
        res.peak      = peak_now;
        res.scale_q8  = autoscale(height_now, peak_now);
        res.rescanned = did_rescan;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        if (fail_total < REPORT_CAP) begin
            $display("[%0t] result %0d: %s is %0d, expected %0d",
                     $time, checked_total, what, got, want);
        end
        fail_total++;
    endtask

    always @(posedge i_clk) begin
        t_peak_scale got;
        t_peak_scale want;
        t_peak_scale fresh;
        if (!i_rst_n) begin
            clear_window();
            height_now = HEIGHT_RESET;
            expected_results.delete();
            fail_total    = 0;
            checked_total = 0;
            rescan_total  = 0;
        end else begin
            if (i_cfg_we) begin
                height_now = i_cfg_wdata;
            end
            // Results are checked before the request of the same edge is predicted.
            if (out_mon.valid && out_mon.ready) begin
                got = '{out_mon.peak, out_mon.scale_q8, out_mon.rescanned};
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result, peak", got.peak, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.peak !== want.peak) begin
                        report_mismatch("peak", got.peak, want.peak);
                    end
                    if (got.scale_q8 !== want.scale_q8) begin
                        report_mismatch("scale_q8", got.scale_q8, want.scale_q8);
                    end
                    if (got.rescanned !== want.rescanned) begin
                        report_mismatch("rescanned", got.rescanned, want.rescanned);
                    end
                    if (want.rescanned) begin
                        rescan_total++;
                    end
                end
                checked_total++;
            end
            if (in_mon.valid && in_mon.ready) begin
                if (predict_peak_scale(in_mon.cmd, in_mon.sample, fresh)) begin
                    expected_results.push_back(fresh);
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_results.size();
        o_checked    <= checked_total;
        o_rescans    <= rescan_total;
    end

endmodule

>>> tb/sv/tb.sv
// Top of the testbench: clock, reset, request stimulus, result stalls and the verdict.
`timescale 1ns / 100ps

module tb;
    import wpa_pkg::*;

    // Cycles to let pass after the last result before the height register is
    // touched, long enough for a rescanning sample to finish.
    localparam int SETTLE_CYCLES = 110;
    // Long receiver hold-off that fills the output register and stalls input.
    localparam int HOLD_CYCLES   = 400;
    // Longest correct gap without any request or result is the hold-off plus
    // a rescan, or a settle pause; the limit is several times that.
    localparam int STALL_LIMIT   = 3000;
    localparam int IDLE_PERCENT  = 6;
    localparam int PHASE_COUNT   = 6;
    localparam int PHASE_RESULTS = 245;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MOST_NEG = 24'h800000;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MOST_POS = 24'h7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MINUS_ONE = 24'hFFFFFF;

    logic                i_clk;
    logic                i_rst_n;
    logic                cfg_we;
    logic [HEIGHT_W-1:0] cfg_wdata;

    wpa_in_if  in_ch ();
    wpa_out_if out_ch ();

    int unsigned fail_count;
    int unsigned pending_count;
    int unsigned checked_count;
    int unsigned rescan_count;

    // Flags shared by the sender and receiver processes, then two counters.
    bit          steady_run;
    bit          hold_request;
    int unsigned requests_sent;
    int unsigned stall_cycles;

    window_peak_autoscale uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    peak_scale_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_mon       (in_ch),
        .out_mon      (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_count),
        .o_checked    (checked_count),
        .o_rescans    (rescan_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Offers one request, after an optional random gap, and returns at the
    // edge where it is accepted. The valid stays high so that a following
    // request goes out back to back without a drop in between.
    task automatic send_request(input logic cmd, input logic signed [SAMPLE_W-1:0] sample);
        while (!steady_run && $urandom_range(99) < IDLE_PERCENT) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.cmd    <= cmd;
        in_ch.sample <= sample;
        requests_sent++;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // The height register may only change while the block is idle: every
    // expected result must be in, and a dropped negative sample that gives no
    // result may still be in flight, so a settle pause follows.
    task automatic set_height(input logic [HEIGHT_W-1:0] height);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= height;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // Draws one random request. Most are non-negative samples whose size is
    // spread over every magnitude, so that peaks rise, hold and decay as old
    // entries slide out of the window. A few are clears, dropped negative
    // samples or fully random words. Returns 1 when the request gives a result.
    function automatic bit draw_request(output logic cmd,
                                        output logic signed [SAMPLE_W-1:0] sample);
        int unsigned pick;
        int unsigned bits;
        pick   = $urandom_range(99);
        cmd    = CMD_SAMPLE;
        sample = SAMPLE_W'($urandom);
        if (pick < 1) begin
            cmd = CMD_CLEAR;
        end else if (pick < 9) begin
            sample[SAMPLE_W-1] = 1'b1;
        end else if (pick < 13) begin
            // Fully random word, either sign.
        end else if (pick < 15) begin
            sample = SAMPLE_MOST_POS;
        end else begin
            bits   = $urandom_range(PEAK_W, 0);
            sample = SAMPLE_W'(longint'($urandom) & ((longint'(1) << bits) - 1));
        end
        return (cmd == CMD_CLEAR) || (sample >= 0);
    endfunction

    // Receiver: ready drops at random at a rate of IDLE_PERCENT percent, never during
    // the steady stretch, and once for a long hold-off while requests keep coming.
    initial begin
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) begin
            @(posedge i_clk);
        end
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            out_ch.ready <= steady_run || ($urandom_range(99) >= IDLE_PERCENT);
            @(posedge i_clk);
        end
    end

    // Watchdog: any cycle with an accepted request or result restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        logic [HEIGHT_W-1:0]         phase_height [PHASE_COUNT];
        logic                        cmd;
        logic signed [SAMPLE_W-1:0]  sample;
        int unsigned                 results_in_phase;

        i_rst_n      <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_wdata    <= HEIGHT_RESET;
        in_ch.valid  <= 1'b0;
        in_ch.cmd    <= CMD_SAMPLE;
        in_ch.sample <= '0;
        steady_run    = 1'b0;
        hold_request  = 1'b0;
        requests_sent = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset height. A clear carrying a negative
        // sample, then zeros with the most negative sample dropped among them,
        // until the 22nd zero sample rescans an all-zero window: the peak
        // falls to zero and the scale saturates. The largest sample and a
        // final clear follow.
        send_request(CMD_CLEAR, SAMPLE_MINUS_ONE);
        repeat (11) send_request(CMD_SAMPLE, '0);
        send_request(CMD_SAMPLE, SAMPLE_MOST_NEG);
        repeat (11) send_request(CMD_SAMPLE, '0);
        send_request(CMD_SAMPLE, SAMPLE_MOST_POS);
        send_request(CMD_CLEAR, SAMPLE_MOST_POS);

        // Random phases, each at its own height: zero height, the largest height,
        // a height of one, then random heights.
        phase_height[0] = '0;
        phase_height[1] = '1;
        phase_height[2] = HEIGHT_W'(1);
        for (int p = 3; p < PHASE_COUNT; p++) begin
            phase_height[p] = HEIGHT_W'($urandom_range(4095, 1));
        end

        for (int p = 0; p < PHASE_COUNT; p++) begin
            set_height(phase_height[p]);
            results_in_phase = 0;
            while (results_in_phase < PHASE_RESULTS) begin
                // Phase 1 sees the long receiver hold-off; phase 3 opens with
                // a stretch where neither side idles.
                if (p == 1 && results_in_phase == 100) begin
                    hold_request = 1'b1;
                end
                steady_run = (p == 3) && (results_in_phase < 150);
                if (draw_request(cmd, sample)) begin
                    results_in_phase++;
                end
                send_request(cmd, sample);
            end
            steady_run = 1'b0;
        end

        // Drain: every expected result must arrive, then a quiet tail in which
        // a stray result would still be caught.
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests over %0d height settings; checked %0d results",
                 requests_sent, PHASE_COUNT + 1, checked_count);
        $display("including %0d window rescans, zero and saturated scales",
                 rescan_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
